// ===== rtl/equal_mass_collision_response_assert.svh =====
// Assertion macros for the collision response RTL.
`ifndef EQUAL_MASS_COLLISION_RESPONSE_ASSERT_SVH
`define EQUAL_MASS_COLLISION_RESPONSE_ASSERT_SVH

// Checked on every rising clock edge while out of reset.
`define EMCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define EMCR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/emcr_pkg.sv =====
// Types, pipeline stage map and helpers for the collision response block.
package emcr_pkg;

    typedef logic signed [31:0] q16_t;
    typedef q16_t [2:0] vec3_t;

    typedef struct packed {
        vec3_t           ap;
        vec3_t           av;
        vec3_t           bp;
        vec3_t           bv;
        logic [2:0][32:0] dmag;
        logic [2:0]      dneg;
    } carry_t;

    localparam int SQ_STEPS  = 35;
    localparam int DIV_STEPS = 31;

    localparam int ST_IN   = 0;
    localparam int ST_SQR  = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_SQ0  = 3;
    localparam int ST_DIV0 = ST_SQ0 + SQ_STEPS;
    localparam int ST_DIVS = ST_DIV0 + 1;
    localparam int ST_U    = ST_DIVS + DIV_STEPS;
    localparam int ST_MUL  = ST_U + 1;
    localparam int ST_DOT  = ST_MUL + 1;
    localparam int ST_PROJ = ST_DOT + 1;
    localparam int ST_OUT  = ST_PROJ + 1;
    localparam int NUM_ST  = ST_OUT + 1;

    localparam logic [30:0] BALL_SIZE_RESET = 31'd65536;

    function automatic q16_t sat40(input logic signed [39:0] x);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = 40'sd2147483647;
        lo = -40'sd2147483648;
        if (x > hi)
        begin
            return q16_t'(hi[31:0]);
        end
        else if (x < lo)
        begin
            return q16_t'(lo[31:0]);
        end
        return q16_t'(x[31:0]);
    endfunction

endpackage

// ===== rtl/equal_mass_collision_response.sv =====
// Top level: fully pipelined equal-mass sphere collision response.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  input    | in_valid / in_ready     | a_pos_*, a_vel_*, b_pos_*, b_vel_*
//  output   | out_valid / out_ready   | a_new_pos_*, a_new_vel_*, b_new_pos_*, b_new_vel_*
//  config   | cfg_wr_en               | cfg_wr_data (ball size, unsigned Q15.16)
//
// One transfer per cycle is sustained while out_ready stays high; the pipeline holds the 35-stage
// square root and the 31-stage divider, one result bit per stage.
// Reset clears all stage valid bits and loads the ball size with 1.0.
// Every stage holds while its successor is full and stalled, so empty stages
// still fill; in_ready drops only when every stage holds a transfer.
`include "equal_mass_collision_response_assert.svh"

module equal_mass_collision_response (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [30:0]   cfg_wr_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  emcr_pkg::q16_t a_pos_x,
    input  emcr_pkg::q16_t a_pos_y,
    input  emcr_pkg::q16_t a_pos_z,
    input  emcr_pkg::q16_t a_vel_x,
    input  emcr_pkg::q16_t a_vel_y,
    input  emcr_pkg::q16_t a_vel_z,
    input  emcr_pkg::q16_t b_pos_x,
    input  emcr_pkg::q16_t b_pos_y,
    input  emcr_pkg::q16_t b_pos_z,
    input  emcr_pkg::q16_t b_vel_x,
    input  emcr_pkg::q16_t b_vel_y,
    input  emcr_pkg::q16_t b_vel_z,
    output logic          out_valid,
    input  logic          out_ready,
    output emcr_pkg::q16_t a_new_pos_x,
    output emcr_pkg::q16_t a_new_pos_y,
    output emcr_pkg::q16_t a_new_pos_z,
    output emcr_pkg::q16_t a_new_vel_x,
    output emcr_pkg::q16_t a_new_vel_y,
    output emcr_pkg::q16_t a_new_vel_z,
    output emcr_pkg::q16_t b_new_pos_x,
    output emcr_pkg::q16_t b_new_pos_y,
    output emcr_pkg::q16_t b_new_pos_z,
    output emcr_pkg::q16_t b_new_vel_x,
    output emcr_pkg::q16_t b_new_vel_y,
    output emcr_pkg::q16_t b_new_vel_z
);
    import emcr_pkg::*;

    logic [30:0]       ball_size_reg;
    logic [NUM_ST-1:0] vld_reg;
    logic [NUM_ST-1:0] en;

    carry_t carry_reg [0:NUM_ST-1];
    carry_t carry_next;

    logic [2:0][64:0] sq_reg;
    logic [69:0]      sq_rad_reg  [0:SQ_STEPS];
    logic [36:0]      sq_rem_reg  [0:SQ_STEPS];
    logic [34:0]      sq_root_reg [0:SQ_STEPS];

    logic [34:0]      dv_len_reg [0:DIV_STEPS];
    logic [2:0][34:0] dv_rem_reg [0:DIV_STEPS];
    logic [2:0][30:0] dv_q_reg   [0:DIV_STEPS];

    vec3_t              u_reg;
    vec3_t              u_m_reg;
    vec3_t              u_d_reg;
    logic [34:0]        len_u_reg;
    logic [2:0][63:0]   pa_reg;
    logic [2:0][63:0]   pb_reg;
    logic signed [34:0] t_reg;
    logic signed [35:0] dot_a_reg;
    logic signed [35:0] dot_b_reg;
    logic [2:0][66:0]   pt_reg;
    logic [2:0][67:0]   na_reg;
    logic [2:0][67:0]   nb_reg;
    logic [2:0][36:0]   s_reg;
    vec3_t              o_ap_reg;
    vec3_t              o_av_reg;
    vec3_t              o_bp_reg;
    vec3_t              o_bv_reg;

    assign en[NUM_ST-1] = !vld_reg[NUM_ST-1] || out_ready;
    for (genvar k = 0; k < NUM_ST - 1; k++)
    begin : g_en
        assign en[k] = !vld_reg[k] || en[k+1];
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NUM_ST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ball_size_reg <= BALL_SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            ball_size_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_ST; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        logic signed [32:0] d;
        vec3_t ap;
        vec3_t bp;
        ap = {a_pos_z, a_pos_y, a_pos_x};
        bp = {b_pos_z, b_pos_y, b_pos_x};
        carry_next.ap = ap;
        carry_next.av = {a_vel_z, a_vel_y, a_vel_x};
        carry_next.bp = bp;
        carry_next.bv = {b_vel_z, b_vel_y, b_vel_x};
        for (int i = 0; i < 3; i++)
        begin
            d = $signed({bp[i][31], bp[i]}) - $signed({ap[i][31], ap[i]});
            carry_next.dneg[i] = d[32];
            carry_next.dmag[i] = d[32] ? 33'(-d) : 33'(d);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            carry_reg[ST_IN] <= carry_next;
        end
        for (int k = 1; k < NUM_ST; k++)
        begin
            if (en[k])
            begin
                carry_reg[k] <= carry_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SQR])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= 65'(66'(carry_reg[ST_IN].dmag[i]) * 66'(carry_reg[ST_IN].dmag[i]));
            end
        end
        if (en[ST_SUM])
        begin
            sq_rad_reg[0]  <= {4'b0000, 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2])};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_sqrt
        logic [38:0] work;
        logic [38:0] trial;
        logic        ge;
        assign work  = {sq_rem_reg[j], sq_rad_reg[j][69:68]};
        assign trial = {2'b00, sq_root_reg[j], 2'b01};
        assign ge    = work >= trial;
        always_ff @(posedge clk)
        begin
            if (en[ST_SQ0 + j])
            begin
                sq_rad_reg[j+1]  <= {sq_rad_reg[j][67:0], 2'b00};
                sq_rem_reg[j+1]  <= ge ? 37'(work - trial) : work[36:0];
                sq_root_reg[j+1] <= {sq_root_reg[j][33:0], ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_DIV0])
        begin
            dv_len_reg[0] <= sq_root_reg[SQ_STEPS];
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= {3'b000, carry_reg[ST_DIV0-1].dmag[i][32:1]};
                dv_q_reg[0][i]   <= '0;
            end
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            logic        nbit;
            logic [35:0] work;
            logic [35:0] dvs;
            logic        ge;
            assign nbit = (j == 0) ? carry_reg[ST_DIVS+j-1].dmag[i][0] : 1'b0;
            assign work = {dv_rem_reg[j][i], nbit};
            assign dvs  = {1'b0, dv_len_reg[j]};
            assign ge   = work >= dvs;
            always_ff @(posedge clk)
            begin
                if (en[ST_DIVS + j])
                begin
                    dv_rem_reg[j+1][i] <= ge ? 35'(work - dvs) : work[34:0];
                    dv_q_reg[j+1][i]   <= {dv_q_reg[j][i][29:0], ge};
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en[ST_DIVS + j])
            begin
                dv_len_reg[j+1] <= dv_len_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [31:0] qv;
        logic signed [35:0] diff;
        logic signed [63:0] tmp;
        logic signed [35:0] dsum_a;
        logic signed [35:0] dsum_b;
        if (en[ST_U])
        begin
            len_u_reg <= dv_len_reg[DIV_STEPS];
            for (int i = 0; i < 3; i++)
            begin
                qv = $signed({1'b0, dv_q_reg[DIV_STEPS][i]});
                if (dv_len_reg[DIV_STEPS] == '0)
                begin
                    u_reg[i] <= '0;
                end
                else
                begin
                    u_reg[i] <= carry_reg[ST_U-1].dneg[i] ? -qv : qv;
                end
            end
        end
        if (en[ST_MUL])
        begin
            u_m_reg <= u_reg;
            diff = $signed({5'b00000, ball_size_reg}) - $signed({1'b0, len_u_reg});
            t_reg <= diff[35:1];
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i] <= 64'($signed(u_reg[i]) * $signed(carry_reg[ST_MUL-1].av[i]));
                pb_reg[i] <= 64'($signed(u_reg[i]) * $signed(carry_reg[ST_MUL-1].bv[i]));
            end
        end
        if (en[ST_DOT])
        begin
            u_d_reg <= u_m_reg;
            dsum_a = '0;
            dsum_b = '0;
            for (int i = 0; i < 3; i++)
            begin
                tmp = $signed(pa_reg[i]);
                dsum_a = dsum_a + 36'($signed(tmp[63:30]));
                tmp = $signed(pb_reg[i]);
                dsum_b = dsum_b + 36'($signed(tmp[63:30]));
                pt_reg[i] <= 67'($signed(u_m_reg[i]) * t_reg);
            end
            dot_a_reg <= dsum_a;
            dot_b_reg <= dsum_b;
        end
        if (en[ST_PROJ])
        begin
            for (int i = 0; i < 3; i++)
            begin
                na_reg[i] <= 68'($signed(u_d_reg[i]) * dot_a_reg);
                nb_reg[i] <= 68'($signed(u_d_reg[i]) * dot_b_reg);
                s_reg[i]  <= pt_reg[i][66:30];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [39:0] ap;
        logic signed [39:0] av;
        logic signed [39:0] bp;
        logic signed [39:0] bv;
        logic signed [39:0] na;
        logic signed [39:0] nb;
        logic signed [39:0] s;
        if (en[ST_OUT])
        begin
            for (int i = 0; i < 3; i++)
            begin
                ap = 40'($signed(carry_reg[ST_OUT-1].ap[i]));
                av = 40'($signed(carry_reg[ST_OUT-1].av[i]));
                bp = 40'($signed(carry_reg[ST_OUT-1].bp[i]));
                bv = 40'($signed(carry_reg[ST_OUT-1].bv[i]));
                na = 40'($signed(na_reg[i][67:30]));
                nb = 40'($signed(nb_reg[i][67:30]));
                s  = 40'($signed(s_reg[i]));
                o_ap_reg[i] <= sat40(ap - s);
                o_bp_reg[i] <= sat40(bp + s);
                o_av_reg[i] <= sat40(av - na + nb);
                o_bv_reg[i] <= sat40(bv - nb + na);
            end
        end
    end

    assign a_new_pos_x = o_ap_reg[0];
    assign a_new_pos_y = o_ap_reg[1];
    assign a_new_pos_z = o_ap_reg[2];
    assign a_new_vel_x = o_av_reg[0];
    assign a_new_vel_y = o_av_reg[1];
    assign a_new_vel_z = o_av_reg[2];
    assign b_new_pos_x = o_bp_reg[0];
    assign b_new_pos_y = o_bp_reg[1];
    assign b_new_pos_z = o_bp_reg[2];
    assign b_new_vel_x = o_bv_reg[0];
    assign b_new_vel_y = o_bv_reg[1];
    assign b_new_vel_z = o_bv_reg[2];

    `EMCR_ASSERT(a_out_from_prev, $rose(out_valid) |-> $past(vld_reg[NUM_ST-2]), "output valid without source")
    `EMCR_ASSERT(a_full_when_blocked, !in_ready |-> (&vld_reg), "input blocked with an empty stage")
    `EMCR_ASSERT(a_zero_len_unit, (vld_reg[ST_MUL-1] && len_u_reg == '0) |-> (u_reg == '0), "nonzero normal for zero length")
    `EMCR_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid, "output valid during reset")

endmodule
